[src/nb2s_pkg.sv]
`default_nettype none
package nb2s_pkg;

  typedef struct packed {
    logic [63:0] double_bits;
    logic        last_in;
  } in_req_t;

  typedef struct packed {
    logic [31:0] single_bits;
    logic        last_out;
  } out_req_t;

  localparam logic [31:0] F32_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  // Class of the source value after decode.
  typedef enum logic [1:0] {
    CLS_FINITE = 2'd0,
    CLS_INF    = 2'd1,
    CLS_NAN    = 2'd2,
    CLS_ZERO   = 2'd3
  } cls_t;

endpackage
`default_nettype wire

[src/nb2s_round.sv]
`default_nettype none
// Rounding stage: shifts the significand right, collects sticky bits and
// rounds to nearest even, with one register stage between shift and round.
module nb2s_round (
  input  wire logic        clk,
  input  wire logic        en_a,
  input  wire logic        en_b,
  input  wire logic [52:0] sig,
  input  wire logic [4:0]  extra,
  output      logic [24:0] kept,
  output      logic        carry24
);
  import nb2s_pkg::*;

  logic [53:0] shd;
  logic        sticky_c;
  logic [24:0] kept_r;
  logic        rnd_r;
  logic        sticky_r;
  logic [24:0] kept_nxt;

  // Shift out 29 + extra bits; keep round and sticky separately.
  always_comb begin
    logic [83:0] wide;
    wide     = {sig, 31'd0} >> extra;
    shd      = wide[83:30];
    sticky_c = |wide[29:0];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      kept_r   <= {1'b0, shd[53:30]};
      rnd_r    <= shd[29];
      sticky_r <= sticky_c | (|shd[28:0]);
    end
  end

  always_comb begin
    kept_nxt = kept_r;
    if (rnd_r && (sticky_r || kept_r[0])) begin
      kept_nxt = kept_r + 25'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      kept    <= kept_nxt;
      carry24 <= kept_nxt[24];
    end
  end

endmodule
`default_nettype wire

[src/narrow_binary64_to_binary32_unit.sv]
`default_nettype none
// Converts one binary64 pattern per cycle to binary32, rounding to nearest
// even, with gradual underflow, overflow to infinity and quiet NaN output.
// Four register stages (decode, shift, round, pack); a request is taken
// every cycle while out_stall is low or out_valid is low, and a stall with
// out_valid high freezes the whole pipeline, which refills without gaps.
module narrow_binary64_to_binary32_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire nb2s_pkg::in_req_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      nb2s_pkg::out_req_t out_data
);
  import nb2s_pkg::*;

  logic [3:0] v_r;
  logic       adv;

  // The pipeline moves when the output register is free or being taken.
  assign adv      = !(v_r[3] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 4'd0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Stage 1: decode.
  logic        s1_sign_r, s1_last_r;
  cls_t        s1_cls_r;
  logic [52:0] s1_sig_r;
  logic [4:0]  s1_extra_r;
  logic [9:0]  s1_fexp_r;
  logic [21:0] s1_pay_r;
  logic        s1_big_r;

  always_ff @(posedge clk) begin
    logic [10:0] e;
    logic [51:0] m;
    logic signed [12:0] fe;
    logic signed [12:0] ex;
    if (adv) begin
      e  = in_data.double_bits[62:52];
      m  = in_data.double_bits[51:0];
      fe = $signed({2'b00, e}) - 13'sd896;
      s1_sign_r <= in_data.double_bits[63];
      s1_last_r <= in_data.last_in;
      s1_pay_r  <= m[50:29];
      s1_sig_r  <= {1'b1, m};
      if (e == 11'h7FF) s1_cls_r <= (m == 52'd0) ? CLS_INF : CLS_NAN;
      else if (e == 11'd0) s1_cls_r <= CLS_ZERO;
      else s1_cls_r <= CLS_FINITE;
      ex = 13'sd1 - fe;
      if (fe > 13'sd0) s1_extra_r <= 5'd0;
      else if (ex > 13'sd31) s1_extra_r <= 5'd31;
      else s1_extra_r <= ex[4:0];
      s1_big_r  <= (fe >= 13'sd255);
      s1_fexp_r <= (fe > 13'sd0 && fe < 13'sd255) ? fe[9:0] : 10'd0;
    end
  end

  // Stages 2 and 3: shift and round; side info follows in registers.
  logic [24:0] kept;
  logic        carry24;
  nb2s_round u_round (
    .clk(clk), .en_a(adv), .en_b(adv),
    .sig(s1_sig_r), .extra(s1_extra_r),
    .kept(kept), .carry24(carry24)
  );

  logic        s2_sign_r, s2_last_r, s2_big_r, s3_sign_r, s3_last_r, s3_big_r;
  cls_t        s2_cls_r, s3_cls_r;
  logic [9:0]  s2_fexp_r, s3_fexp_r;
  logic [21:0] s2_pay_r, s3_pay_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      {s2_sign_r, s2_last_r, s2_big_r, s2_cls_r, s2_fexp_r, s2_pay_r} <=
        {s1_sign_r, s1_last_r, s1_big_r, s1_cls_r, s1_fexp_r, s1_pay_r};
      {s3_sign_r, s3_last_r, s3_big_r, s3_cls_r, s3_fexp_r, s3_pay_r} <=
        {s2_sign_r, s2_last_r, s2_big_r, s2_cls_r, s2_fexp_r, s2_pay_r};
    end
  end

  // Stage 4: pack.
  always_ff @(posedge clk) begin
    logic [31:0] r;
    logic [9:0]  fe;
    if (adv) begin
      fe = s3_fexp_r + {9'd0, carry24};
      case (s3_cls_r)
        CLS_INF:  r = F32_INF;
        CLS_NAN:  r = F32_QNAN | {10'd0, s3_pay_r};
        CLS_ZERO: r = 32'd0;
        default: begin
          if (s3_big_r) r = F32_INF;
          else if (s3_fexp_r == 10'd0) r = {7'd0, kept};
          else if (fe >= 10'd255) r = F32_INF;
          else r = {1'b0, fe[7:0], carry24 ? kept[23:1] : kept[22:0]};
        end
      endcase
      out_data.single_bits <= {s3_sign_r, r[30:0]};
      out_data.last_out    <= s3_last_r;
    end
  end

  assign out_valid = v_r[3];

endmodule
`default_nettype wire
